// ----- hdl/crb_pkg.sv -----
// Shared types and constants of the Catmull-Rom to cubic Bezier converter.
`default_nettype none
package crb_pkg;

    localparam int CRB_COORD_W  = 24;
    localparam int CRB_EXT_W    = CRB_COORD_W + 2;
    localparam int CRB_DIFF_W   = CRB_COORD_W + 3;
    localparam int CRB_FACTOR_W = 16;

    localparam logic [CRB_FACTOR_W-1:0] CRB_FACTOR_RESET = 16'd10923;

    typedef logic signed [CRB_COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        logic   stroke_end;
    } t_point_in;

    typedef struct packed {
        t_coord seg_start_x;
        t_coord seg_start_y;
        t_coord ctrl1_x;
        t_coord ctrl1_y;
        t_coord ctrl2_x;
        t_coord ctrl2_y;
        t_coord seg_end_x;
        t_coord seg_end_y;
        logic   final_segment;
    } t_segment_out;

endpackage
`default_nettype wire

// ----- hdl/catmull_rom_bezier_controls_unit.sv -----
// Top level: streaming Catmull-Rom stroke to cubic Bezier segment converter.
//
// Stroke points enter on the input channel (i_in_valid / o_in_stall); each
// transaction carries one point and a stroke_end mark. Bezier segments leave
// on the output channel (o_out_valid / i_out_stall), one per transaction.
// The tangent factor is written through i_cfg_wr_en / i_cfg_wr_data.
//
// An accepted point is turned into zero, one or two segment jobs in the
// cycle it is taken; jobs sit in a two-entry job register, and one job per
// cycle, unless the output stalls, is scaled and saturated into the output
// register, so a segment passes both registers. One point is taken every
// cycle while o_in_stall is low; a stroke_end point with two segments
// holds the input off while the single output register takes its first job.
//
// Reset empties the point window, the job register and the output register,
// and loads the tangent factor with one sixth. While the receiver stalls,
// the output transaction holds; the block keeps accepting points until a
// segment job waits behind the held output register, then raises o_in_stall.
`default_nettype none
module catmull_rom_bezier_controls_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire crb_pkg::t_point_in                i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output crb_pkg::t_segment_out                  o_out_data,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [crb_pkg::CRB_FACTOR_W-1:0]  i_cfg_wr_data
);
    import crb_pkg::*;

    localparam int W  = CRB_COORD_W;
    localparam int EW = CRB_EXT_W;
    localparam int DW = CRB_DIFF_W;
    localparam int PW = DW + CRB_FACTOR_W + 1;
    localparam int SW = W + 5;

    localparam logic signed [PW-1:0] RND_BIAS = PW'(32'sd32768);
    localparam logic signed [W-1:0]  COORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  COORD_MIN = {1'b1, {(W-1){1'b0}}};

    typedef logic signed [EW-1:0] t_ext;
    typedef logic signed [DW-1:0] t_diff;

    // One segment waiting to be scaled: index 0 is x, index 1 is y.
    typedef struct packed {
        logic [1:0][W-1:0]  pi;
        logic [1:0][W-1:0]  pi1;
        logic [1:0][DW-1:0] d1;
        logic [1:0][DW-1:0] d2;
        logic               fin;
    } t_job;

    function automatic t_ext ext_pt(input t_coord a);
        return {{2{a[W-1]}}, a};
    endfunction

    // Phantom point 2*a - b, exact.
    function automatic t_ext mirror_pt(input t_coord a, input t_coord b);
        t_ext a2;
        a2 = {a[W-1], a, 1'b0};
        return a2 - ext_pt(b);
    endfunction

    function automatic t_diff diff_pt(input t_ext a, input t_ext b);
        return {a[EW-1], a} - {b[EW-1], b};
    endfunction

    // base +/- round(f * d / 2^16), saturated to the coordinate range.
    function automatic t_coord ctrl_pt(input t_coord base, input t_diff d,
                                       input logic [CRB_FACTOR_W-1:0] f, input logic neg);
        logic signed [PW-1:0] prod;
        logic signed [PW-1:0] rnd;
        logic signed [DW:0]   scaled;
        logic signed [SW-1:0] sum;
        prod   = d * $signed({1'b0, f});
        rnd    = prod + RND_BIAS;
        scaled = rnd[PW-1:16];
        if (neg) begin
            sum = $signed({{5{base[W-1]}}, base}) - $signed({scaled[DW], scaled});
        end else begin
            sum = $signed({{5{base[W-1]}}, base}) + $signed({scaled[DW], scaled});
        end
        if ((&sum[SW-1:W-1]) || !(|sum[SW-1:W-1])) begin
            return sum[W-1:0];
        end else if (sum[SW-1]) begin
            return COORD_MIN;
        end else begin
            return COORD_MAX;
        end
    endfunction

    logic [CRB_FACTOR_W-1:0] r_factor;
    logic [2:0][1:0][W-1:0]  r_win;
    logic [2:0][1:0][W-1:0]  n_win;
    logic [1:0]              r_held;
    logic [1:0]              n_held;
    logic                    r_j0_v;
    logic                    r_j1_v;
    t_job                    r_j0;
    t_job                    r_j1;
    logic                    r_out_valid;
    t_segment_out            r_out;
    t_segment_out            n_out;

    logic       out_free;
    logic       move;
    logic       accept;
    logic [1:0] job_cnt;
    t_job       job_a;
    t_job       job_b;
    t_coord     q [2];

    assign out_free   = !r_out_valid || !i_out_stall;
    assign move       = r_j0_v && out_free;
    assign o_in_stall = r_j0_v && !(out_free && !r_j1_v);
    assign accept     = i_in_valid && !o_in_stall;

    // Segment jobs caused by the incoming point.
    always_comb begin
        t_coord a;
        t_coord b;
        t_ext   pp;
        pp   = '0;
        q[0] = i_in_data.point_x;
        q[1] = i_in_data.point_y;
        job_a = '0;
        job_b = '0;
        for (int ax = 0; ax < 2; ax++) begin
            if (r_held == 2'd1) begin
                job_a.pi[ax]  = r_win[0][ax];
                job_a.pi1[ax] = q[ax];
                job_a.d1[ax]  = diff_pt(ext_pt(q[ax]), mirror_pt(r_win[0][ax], q[ax]));
                job_a.d2[ax]  = diff_pt(mirror_pt(q[ax], r_win[0][ax]),
                                        ext_pt(r_win[0][ax]));
            end else begin
                a  = (r_held == 2'd2) ? r_win[0][ax] : r_win[1][ax];
                b  = (r_held == 2'd2) ? r_win[1][ax] : r_win[2][ax];
                pp = (r_held == 2'd2) ? mirror_pt(r_win[0][ax], r_win[1][ax])
                                      : ext_pt(r_win[0][ax]);
                job_a.pi[ax]  = a;
                job_a.pi1[ax] = b;
                job_a.d1[ax]  = diff_pt(ext_pt(b), pp);
                job_a.d2[ax]  = diff_pt(ext_pt(q[ax]), ext_pt(a));
            end
            b = (r_held == 2'd2) ? r_win[1][ax] : r_win[2][ax];
            a = (r_held == 2'd2) ? r_win[0][ax] : r_win[1][ax];
            job_b.pi[ax]  = b;
            job_b.pi1[ax] = q[ax];
            job_b.d1[ax]  = diff_pt(ext_pt(q[ax]), ext_pt(a));
            job_b.d2[ax]  = diff_pt(mirror_pt(q[ax], b), ext_pt(b));
        end
        job_a.fin = (r_held == 2'd1);
        job_b.fin = 1'b1;
        if (i_in_data.stroke_end) begin
            case (r_held)
                2'd0:    job_cnt = 2'd0;
                2'd1:    job_cnt = 2'd1;
                default: job_cnt = 2'd2;
            endcase
        end else begin
            job_cnt = (r_held >= 2'd2) ? 2'd1 : 2'd0;
        end
    end

    // Window update for the incoming point.
    always_comb begin
        n_win  = r_win;
        n_held = r_held;
        if (i_in_data.stroke_end) begin
            n_held = 2'd0;
        end else begin
            case (r_held)
                2'd0: begin
                    n_win[0] = {q[1], q[0]};
                    n_held   = 2'd1;
                end
                2'd1: begin
                    n_win[1] = {q[1], q[0]};
                    n_held   = 2'd2;
                end
                2'd2: begin
                    n_win[2] = {q[1], q[0]};
                    n_held   = 2'd3;
                end
                default: begin
                    n_win[0] = r_win[1];
                    n_win[1] = r_win[2];
                    n_win[2] = {q[1], q[0]};
                end
            endcase
        end
    end

    // Scale and saturate the job at the head of the job register.
    always_comb begin
        n_out.seg_start_x   = r_j0.pi[0];
        n_out.seg_start_y   = r_j0.pi[1];
        n_out.ctrl1_x       = ctrl_pt(r_j0.pi[0], r_j0.d1[0], r_factor, 1'b0);
        n_out.ctrl1_y       = ctrl_pt(r_j0.pi[1], r_j0.d1[1], r_factor, 1'b0);
        n_out.ctrl2_x       = ctrl_pt(r_j0.pi1[0], r_j0.d2[0], r_factor, 1'b1);
        n_out.ctrl2_y       = ctrl_pt(r_j0.pi1[1], r_j0.d2[1], r_factor, 1'b1);
        n_out.seg_end_x     = r_j0.pi1[0];
        n_out.seg_end_y     = r_j0.pi1[1];
        n_out.final_segment = r_j0.fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor    <= CRB_FACTOR_RESET;
            r_held      <= 2'd0;
            r_j0_v      <= 1'b0;
            r_j1_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_factor <= i_cfg_wr_data;
            end
            if (accept) begin
                r_held <= n_held;
                r_j0_v <= (job_cnt != 2'd0);
                r_j1_v <= (job_cnt == 2'd2);
            end else if (move) begin
                r_j0_v <= r_j1_v;
                r_j1_v <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_j0_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
            r_j0  <= job_a;
            r_j1  <= job_b;
        end else if (move) begin
            r_j0 <= r_j1;
        end
        if (move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ----- hdl/crb_checker.sv -----
// Port-level assertions for the converter top level, with the bind that attaches them.
`default_nettype none
module crb_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_in_stall,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_stall,
    input wire crb_pkg::t_segment_out             o_out_data
);
    import crb_pkg::*;

    // After reset nothing is pending on the output side.
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // After reset the job register is empty, so points are taken at once.
    a_reset_stall: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // A stall with an empty output register means a job is about to move out.
    a_stall_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_stall && !o_out_valid) |=> o_out_valid)
        else $error("input stalled while no segment is offered");

    // A stalled segment transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled segment changed");

endmodule

bind catmull_rom_bezier_controls_unit crb_checker u_crb_checker (.*);
`default_nettype wire

// ----- test/crb_segment_checker.sv -----
`timescale 1ns / 1ps
// Checker that predicts Bezier segments from accepted stroke points and compares them.
module crb_segment_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_stall,
    input  wire crb_pkg::t_point_in                i_in_data,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_stall,
    input  wire crb_pkg::t_segment_out             i_out_data,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [crb_pkg::CRB_FACTOR_W-1:0]  i_cfg_wr_data,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    import crb_pkg::*;

    typedef struct packed {
        longint x;
        longint y;
    } t_xy;

    localparam longint COORD_HI = (longint'(1) <<< (CRB_COORD_W - 1)) - 1;
    localparam longint COORD_LO = -COORD_HI - 1;
    localparam int     SEG_FIELDS = 9;

    logic [CRB_FACTOR_W-1:0] tangent_factor = CRB_FACTOR_RESET;
    t_xy                     stroke_window [3];
    int                      points_held = 0;
    t_segment_out            segments_due [$];

    // Product with the Q0.16 tangent factor, rounded to an integer with ties going up.
    function automatic longint tangent_scale(longint d);
        longint prod;
        prod = d * longint'(tangent_factor);
        return (prod + 64'sd32768) >>> 16;
    endfunction

    function automatic t_coord clamp_coord(longint v);
        if (v > COORD_HI) return t_coord'(COORD_HI);
        if (v < COORD_LO) return t_coord'(COORD_LO);
        return t_coord'(v);
    endfunction

    // Phantom neighbor: b reflected through a.
    function automatic t_xy reflect(t_xy a, t_xy b);
        t_xy r;
        r.x = 2 * a.x - b.x;
        r.y = 2 * a.y - b.y;
        return r;
    endfunction

    function automatic void add_segment(t_xy pp, t_xy pi, t_xy pi1, t_xy pn, logic fin);
        t_segment_out seg;
        seg.seg_start_x   = t_coord'(pi.x);
        seg.seg_start_y   = t_coord'(pi.y);
        seg.ctrl1_x       = clamp_coord(pi.x + tangent_scale(pi1.x - pp.x));
        seg.ctrl1_y       = clamp_coord(pi.y + tangent_scale(pi1.y - pp.y));
        seg.ctrl2_x       = clamp_coord(pi1.x - tangent_scale(pn.x - pi.x));
        seg.ctrl2_y       = clamp_coord(pi1.y - tangent_scale(pn.y - pi.y));
        seg.seg_end_x     = t_coord'(pi1.x);
        seg.seg_end_y     = t_coord'(pi1.y);
        seg.final_segment = fin;
        segments_due.push_back(seg);
    endfunction

    function automatic void clear_stroke();
        for (int k = 0; k < 3; k++) stroke_window[k] = '0;
        points_held = 0;
    endfunction

    task automatic predict_segments(input t_point_in pt);
        t_xy q;
        t_xy pa;
        t_xy pb;
        t_xy pc;
        q.x = $signed(pt.point_x);
        q.y = $signed(pt.point_y);
        pa  = stroke_window[0];
        pb  = stroke_window[1];
        pc  = stroke_window[2];
        if (pt.stroke_end) begin
            case (points_held)
                1: begin
                    add_segment(reflect(pa, q), pa, q, reflect(q, pa), 1'b1);
                end
                2: begin
                    add_segment(reflect(pa, pb), pa, pb, q, 1'b0);
                    add_segment(pa, pb, q, reflect(q, pb), 1'b1);
                end
                3: begin
                    add_segment(pa, pb, pc, q, 1'b0);
                    add_segment(pb, pc, q, reflect(q, pc), 1'b1);
                end
                default: ;
            endcase
            clear_stroke();
        end else begin
            if (points_held == 2) begin
                add_segment(reflect(pa, pb), pa, pb, q, 1'b0);
            end else if (points_held == 3) begin
                add_segment(pa, pb, pc, q, 1'b0);
            end
            if (points_held == 3) begin
                stroke_window[0] = pb;
                stroke_window[1] = pc;
                stroke_window[2] = q;
            end else begin
                stroke_window[points_held] = q;
                points_held++;
            end
        end
    endtask

    function automatic logic signed [63:0] seg_field(t_segment_out s, int k);
        logic signed [63:0] v;
        case (k)
            0:       v = $signed(s.seg_start_x);
            1:       v = $signed(s.seg_start_y);
            2:       v = $signed(s.ctrl1_x);
            3:       v = $signed(s.ctrl1_y);
            4:       v = $signed(s.ctrl2_x);
            5:       v = $signed(s.ctrl2_y);
            6:       v = $signed(s.seg_end_x);
            7:       v = $signed(s.seg_end_y);
            default: v = {63'd0, s.final_segment};
        endcase
        return v;
    endfunction

    function automatic string field_label(int k);
        case (k)
            0:       return "seg_start_x";
            1:       return "seg_start_y";
            2:       return "ctrl1_x";
            3:       return "ctrl1_y";
            4:       return "ctrl2_x";
            5:       return "ctrl2_y";
            6:       return "seg_end_x";
            7:       return "seg_end_y";
            default: return "final_segment";
        endcase
    endfunction

    task automatic check_segment(input t_segment_out got);
        t_segment_out want;
        if (segments_due.size() == 0) begin
            $display("%0t: segment with none predicted: %h", $time, got);
            o_fail_count++;
            return;
        end
        want = segments_due.pop_front();
        if (want !== got) begin
            o_fail_count++;
            for (int k = 0; k < SEG_FIELDS; k++) begin
                if (seg_field(want, k) !== seg_field(got, k)) begin
                    $display("%0t: %s expected %0d, actual %0d", $time, field_label(k),
                             seg_field(want, k), seg_field(got, k));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tangent_factor = CRB_FACTOR_RESET;
            clear_stroke();
            segments_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                tangent_factor = i_cfg_wr_data;
            end
            // A point's segments leave only after passing the job register and the
            // output register, so the order of these two within one edge does not matter.
            if (i_out_valid && !i_out_stall) begin
                check_segment(i_out_data);
            end
            if (i_in_valid && !i_in_stall) begin
                predict_segments(i_in_data);
            end
        end
        o_pending = segments_due.size();
    end

endmodule

// ----- test/tb_catmull_rom_bezier_controls_unit.sv -----
`timescale 1ns / 1ps
// Testbench top: stroke stimulus, clock, reset and verdict for the Bezier converter.
module tb_catmull_rom_bezier_controls_unit;
    import crb_pkg::*;

    typedef enum int {
        STYLE_WALK,
        STYLE_WIDE,
        STYLE_EDGE
    } t_stroke_style;

    localparam t_coord COORD_MAX     = {1'b0, {(CRB_COORD_W - 1){1'b1}}};
    localparam t_coord COORD_MIN     = {1'b1, {(CRB_COORD_W - 1){1'b0}}};
    localparam int     SETTLE_CYCLES = 4;
    localparam int     PHASE_ITEMS   = 190;
    localparam int     DRAIN_LIMIT   = 2000;
    localparam int     CYCLE_LIMIT   = 200000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    t_point_in               i_in_data;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    t_segment_out            o_out_data;
    logic                    i_cfg_wr_en;
    logic [CRB_FACTOR_W-1:0] i_cfg_wr_data;

    int checker_fails;
    int checker_pending;
    int gap_pct     = 19;
    int stall_pct   = 19;
    int cycle_count = 0;
    int drain_wait;

    catmull_rom_bezier_controls_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    crb_segment_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_data    (o_out_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_fail_count  (checker_fails),
        .o_pending     (checker_pending)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= (int'($urandom_range(99)) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_catmull_rom_bezier_controls_unit NOT OK");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_point(input t_coord x, input t_coord y, input logic last);
        t_point_in pt;
        while (int'($urandom_range(99)) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        pt.point_x    = x;
        pt.point_y    = y;
        pt.stroke_end = last;
        i_in_valid <= 1'b1;
        i_in_data  <= pt;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Hold the sender until every predicted segment has been taken, then let
    // any point that makes no segment clear the pipeline.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (checker_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_factor(input logic [CRB_FACTOR_W-1:0] value);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic t_coord pick_coord(t_coord prev, t_stroke_style style);
        case (style)
            STYLE_WALK: return prev + t_coord'($urandom_range(4095)) - t_coord'(2048);
            STYLE_WIDE: return t_coord'($urandom);
            default: begin
                case ($urandom_range(4))
                    0:       return COORD_MAX;
                    1:       return COORD_MIN;
                    2:       return t_coord'(0);
                    3:       return t_coord'(-1);
                    default: return t_coord'(1);
                endcase
            end
        endcase
    endfunction

    task automatic send_stroke(input int len, input t_stroke_style style);
        t_coord x;
        t_coord y;
        x = t_coord'($urandom);
        y = t_coord'($urandom);
        for (int k = 0; k < len; k++) begin
            x = pick_coord(x, style);
            y = pick_coord(y, style);
            send_point(x, y, k == len - 1);
        end
    endtask

    // Mostly pen-like strokes of a few points, with some long and some single ones.
    task automatic run_strokes(input int item_goal);
        int            sent;
        int            len;
        int            r;
        t_stroke_style style;
        sent = 0;
        while (sent < item_goal) begin
            r = $urandom_range(99);
            if (r < 8)       len = 1;
            else if (r < 70) len = $urandom_range(8, 2);
            else if (r < 92) len = $urandom_range(30, 9);
            else             len = $urandom_range(80, 31);
            r = $urandom_range(99);
            style = (r < 45) ? STYLE_WALK : (r < 85) ? STYLE_WIDE : STYLE_EDGE;
            send_stroke(len, style);
            sent += len;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single point stroke: nothing comes out.
        send_point(COORD_MAX, COORD_MIN, 1'b1);
        // Two points: one final segment with phantoms on both sides.
        send_point(COORD_MAX, COORD_MAX, 1'b0);
        send_point(COORD_MIN, COORD_MIN, 1'b1);
        // Stroke end with two points held.
        send_point(t_coord'(0), t_coord'(0), 1'b0);
        send_point(t_coord'(256), t_coord'(-256), 1'b0);
        send_point(t_coord'(-1), t_coord'(1), 1'b1);
        // Stroke end with three points held.
        send_point(COORD_MIN, COORD_MAX, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 1'b0);
        send_point(t_coord'(0), t_coord'(0), 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b1);
        // Window full and shifting before the end.
        send_point(t_coord'(1), t_coord'(-1), 1'b0);
        send_point(t_coord'(-1), t_coord'(1), 1'b0);
        send_point(COORD_MAX, t_coord'(0), 1'b0);
        send_point(t_coord'(0), COORD_MIN, 1'b0);
        send_point(t_coord'(100), t_coord'(100), 1'b1);

        // Largest factor drives the control points into saturation.
        write_factor({CRB_FACTOR_W{1'b1}});
        send_point(COORD_MAX, COORD_MIN, 1'b0);
        send_point(COORD_MIN, COORD_MAX, 1'b1);
        send_point(COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b0);
        send_point(COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b1);
        run_strokes(PHASE_ITEMS);

        write_factor('0);
        run_strokes(PHASE_ITEMS);

        // A stretch with neither side idling.
        write_factor(16'h8000);
        gap_pct   = 0;
        stall_pct = 0;
        run_strokes(PHASE_ITEMS);
        gap_pct   = 19;
        stall_pct = 19;

        write_factor(CRB_FACTOR_W'($urandom));
        run_strokes(PHASE_ITEMS);
        write_factor(16'h0001);
        run_strokes(PHASE_ITEMS);
        write_factor(CRB_FACTOR_W'($urandom));
        run_strokes(PHASE_ITEMS);
        write_factor(CRB_FACTOR_RESET);
        run_strokes(PHASE_ITEMS);

        i_in_valid <= 1'b0;
        drain_wait = 0;
        while (checker_pending != 0 && drain_wait < DRAIN_LIMIT) begin
            @(negedge i_clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (checker_pending != 0) begin
            $display("%0t: %0d predicted segments never arrived", $time, checker_pending);
        end
        if (checker_fails == 0 && checker_pending == 0) begin
            $display("tb_catmull_rom_bezier_controls_unit OK");
        end else begin
            $display("tb_catmull_rom_bezier_controls_unit NOT OK");
        end
        $finish;
    end

endmodule
